// ===== rtl/fga_pkg.sv =====
// Shared constants, types and helpers for the flowgram gapped aligner.
`default_nettype none
package fga_pkg;

    localparam int MAX_FLOWS   = 512;
    localparam int NUM_BINS    = 1024;
    localparam int GAP_SPAN    = 4;
    localparam int COLS        = MAX_FLOWS + 1;
    localparam int ROWS        = GAP_SPAN + 1;
    localparam int SCORE_DEPTH = ROWS * COLS;
    localparam int MOVE_DEPTH  = COLS * COLS;
    localparam int TABLE_DEPTH = NUM_BINS * NUM_BINS;
    localparam int SCORE_AW    = $clog2(SCORE_DEPTH);
    localparam int MOVE_AW     = $clog2(MOVE_DEPTH);
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int BIN_W       = 10;
    localparam int FLOW_AW     = 9;
    localparam int LEN_W       = 10;
    localparam int COST_W      = 32;
    localparam int GAP_W       = 31;
    localparam int PLEN_W      = 11;
    localparam int SLOT_W      = 3;
    localparam int ACC_W       = 41;
    localparam int SUM_W       = 35;
    localparam int SEQ_W       = BIN_W + COST_W;

    localparam logic [GAP_W-1:0] GAP_RESET = 31'd983040;

    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_SEQ_A = 2'd1;
    localparam logic [1:0] MODE_SEQ_B = 2'd2;
    localparam logic [1:0] MODE_ALIGN = 2'd3;

    localparam logic [1:0] MV_DIAG = 2'd0;
    localparam logic [1:0] MV_UP   = 2'd1;
    localparam logic [1:0] MV_LEFT = 2'd2;

    typedef struct packed {
        logic load;
        logic init;
        logic row0;
        logic row_begin;
        logic col0;
        logic cell_rd;
        logic cell_tab;
        logic cell_sum;
        logic cell_wr;
        logic fin_rd;
        logic fin_lat;
        logic tb_step;
    } t_cmd;

    typedef struct packed {
        logic j_last;
        logic i_last;
        logic at_origin;
        logic tb_last;
    } t_status;

    function automatic logic signed [COST_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sd2147483647);
        lo = -SUM_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] sat_border(input logic [ACC_W-1:0] v);
        if (v > ACC_W'(32'h7FFFFFFF)) begin
            return 32'h7FFFFFFF;
        end
        return v[COST_W-1:0];
    endfunction

    function automatic logic [SCORE_AW-1:0] row_base(input logic [SLOT_W-1:0] slot);
        return SCORE_AW'(slot) * SCORE_AW'(COLS);
    endfunction

    function automatic logic [MOVE_AW-1:0] move_addr(input logic [LEN_W-1:0] i,
                                                     input logic [LEN_W-1:0] j);
        return MOVE_AW'(i) * MOVE_AW'(COLS) + MOVE_AW'(j);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fga_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/fga_ctrl.sv =====
// Controller state machine: sequences loads, matrix fill, traceback and result.
`default_nettype none
module fga_ctrl import fga_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [1:0] i_mode,
    input  wire t_status    i_status,
    output t_cmd            o_cmd,
    output logic            busy,
    output logic            o_valid
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROW0 = 4'd1;
    localparam logic [3:0] S_ROWA = 4'd2;
    localparam logic [3:0] S_ROWB = 4'd3;
    localparam logic [3:0] S_C0   = 4'd4;
    localparam logic [3:0] S_C1   = 4'd5;
    localparam logic [3:0] S_C2   = 4'd6;
    localparam logic [3:0] S_C3   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_FIND = 4'd9;
    localparam logic [3:0] S_TB0  = 4'd10;
    localparam logic [3:0] S_TB1  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_mode == MODE_ALIGN) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_ROW0;
                    end
                end
            end
            S_ROW0: begin
                o_cmd.row0 = 1'b1;
                if (i_status.j_last) begin
                    n_state = i_status.i_last ? S_FIN : S_ROWA;
                end
            end
            S_ROWA: begin
                o_cmd.row_begin = 1'b1;
                n_state         = S_ROWB;
            end
            S_ROWB: begin
                o_cmd.col0 = 1'b1;
                if (i_status.j_last) begin
                    n_state = i_status.i_last ? S_FIN : S_ROWA;
                end else begin
                    n_state = S_C0;
                end
            end
            S_C0: begin
                o_cmd.cell_rd = 1'b1;
                n_state       = S_C1;
            end
            S_C1: begin
                o_cmd.cell_tab = 1'b1;
                n_state        = S_C2;
            end
            S_C2: begin
                o_cmd.cell_sum = 1'b1;
                n_state        = S_C3;
            end
            S_C3: begin
                o_cmd.cell_wr = 1'b1;
                if (i_status.j_last) begin
                    n_state = i_status.i_last ? S_FIN : S_ROWA;
                end else begin
                    n_state = S_C0;
                end
            end
            S_FIN: begin
                o_cmd.fin_rd = 1'b1;
                n_state      = S_FIND;
            end
            S_FIND: begin
                o_cmd.fin_lat = 1'b1;
                n_state       = i_status.at_origin ? S_DONE : S_TB0;
            end
            S_TB0: begin
                n_state = S_TB1;
            end
            S_TB1: begin
                o_cmd.tb_step = 1'b1;
                n_state       = i_status.tb_last ? S_DONE : S_TB0;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
endmodule
`default_nettype wire

// ===== rtl/fga_dp.sv =====
// Datapath: load stores, score rows, move matrix, cell arithmetic and traceback.
`default_nettype none
module fga_dp import fga_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    input  wire logic [1:0]               i_mode,
    input  wire logic [BIN_W-1:0]         i_table_row,
    input  wire logic [BIN_W-1:0]         i_table_col,
    input  wire logic signed [COST_W-1:0] i_table_value,
    input  wire logic [FLOW_AW-1:0]       i_flow_index,
    input  wire logic [BIN_W-1:0]         i_flow_bin,
    input  wire logic signed [COST_W-1:0] i_flow_cost,
    input  wire logic [LEN_W-1:0]         i_len_a,
    input  wire logic [LEN_W-1:0]         i_len_b,
    input  wire logic                     i_cfg_we,
    input  wire logic [GAP_W-1:0]         i_cfg_wdata,
    output logic signed [COST_W-1:0]      o_distance,
    output logic [PLEN_W-1:0]             o_path_length,
    output logic [PLEN_W-1:0]             o_compared_length
);
    logic [GAP_W-1:0]         r_gap;
    logic [LEN_W-1:0]         r_la, r_lb, r_i, r_j;
    logic [SLOT_W-1:0]        r_slot;
    logic [ACC_W-1:0]         r_acc0, r_accr;
    logic [BIN_W-1:0]         r_bin_a;
    logic signed [COST_W-1:0] r_ca, r_cb, r_sd, r_su;
    logic signed [COST_W-1:0] r_sh [GAP_SPAN];
    logic signed [COST_W-1:0] r_c1, r_c2, r_c3;
    logic                     r_ok2, r_ok3;
    logic signed [COST_W-1:0] r_dist;
    logic [PLEN_W-1:0]        r_plen, r_lead;
    logic [1:0]               r_first;
    logic                     r_run;

    logic [SEQ_W-1:0]         seqa_rdata, seqb_rdata;
    logic [COST_W-1:0]        tab_rdata, sd_rdata, su_rdata;
    logic [1:0]               mv_rdata;

    logic [LEN_W-1:0]         la_sat, lb_sat, j_nx;
    logic [SLOT_W-1:0]        slot_m1, slot_m4;
    logic [SCORE_AW-1:0]      sd_raddr, su_raddr, sc_waddr;
    logic [COST_W-1:0]        sc_wdata;
    logic                     sc_we;
    logic [1:0]               mv_wdata, mv_pick;
    logic                     mv_we;
    logic signed [COST_W-1:0] m_val;
    logic [SUM_W-1:0]         span;
    logic signed [SUM_W-1:0]  sum1, sum2, sum3;
    logic                     lt12, lt13, lt23, lt3m;
    logic [2:0]               tb_steps;
    logic [LEN_W-1:0]         tb_i, tb_j;
    logic [1:0]               tb_f;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            r_gap <= i_cfg_wdata;
        end
    end

    assign la_sat  = (i_len_a > LEN_W'(MAX_FLOWS)) ? LEN_W'(MAX_FLOWS) : i_len_a;
    assign lb_sat  = (i_len_b > LEN_W'(MAX_FLOWS)) ? LEN_W'(MAX_FLOWS) : i_len_b;
    assign j_nx    = r_j + 1'b1;
    assign slot_m1 = (r_slot == '0) ? SLOT_W'(ROWS - 1) : r_slot - 1'b1;
    assign slot_m4 = (r_slot == SLOT_W'(ROWS - 1)) ? '0 : r_slot + 1'b1;

    fga_ram #(.WIDTH(COST_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && i_mode == MODE_TABLE),
        .i_waddr ({i_table_row, i_table_col}),
        .i_wdata (i_table_value),
        .i_raddr ({r_bin_a, seqb_rdata[SEQ_W-1:COST_W]}),
        .o_rdata (tab_rdata)
    );

    fga_ram #(.WIDTH(SEQ_W), .DEPTH(MAX_FLOWS)) u_seq_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && i_mode == MODE_SEQ_A),
        .i_waddr (i_flow_index),
        .i_wdata ({i_flow_bin, i_flow_cost}),
        .i_raddr (r_i[FLOW_AW-1:0]),
        .o_rdata (seqa_rdata)
    );

    fga_ram #(.WIDTH(SEQ_W), .DEPTH(MAX_FLOWS)) u_seq_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && i_mode == MODE_SEQ_B),
        .i_waddr (i_flow_index),
        .i_wdata ({i_flow_bin, i_flow_cost}),
        .i_raddr (r_j[FLOW_AW-1:0]),
        .o_rdata (seqb_rdata)
    );

    // Two copies of the rolling score rows give the diagonal and up reads.
    assign sd_raddr = row_base(i_cmd.fin_rd ? r_slot : slot_m1) + SCORE_AW'(r_j);
    assign su_raddr = row_base(slot_m4) + SCORE_AW'(j_nx);
    assign sc_waddr = row_base(r_slot) + SCORE_AW'(r_j);
    assign sc_we    = i_cmd.row0 | i_cmd.col0 | i_cmd.cell_wr;
    assign sc_wdata = i_cmd.row0 ? sat_border(r_acc0) :
                      i_cmd.col0 ? sat_border(r_accr) : m_val;

    fga_ram #(.WIDTH(COST_W), .DEPTH(SCORE_DEPTH)) u_score_d (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (sd_raddr),
        .o_rdata (sd_rdata)
    );

    fga_ram #(.WIDTH(COST_W), .DEPTH(SCORE_DEPTH)) u_score_u (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (su_raddr),
        .o_rdata (su_rdata)
    );

    assign mv_we    = sc_we;
    assign mv_wdata = i_cmd.row0 ? MV_LEFT : i_cmd.col0 ? MV_UP : mv_pick;

    fga_ram #(.WIDTH(2), .DEPTH(MOVE_DEPTH)) u_move (
        .i_clk   (i_clk),
        .i_we    (mv_we),
        .i_waddr (move_addr(r_i, r_j)),
        .i_wdata (mv_wdata),
        .i_raddr (move_addr(r_i, r_j)),
        .o_rdata (mv_rdata)
    );

    // Cell sums, formed exactly and then saturated.
    assign span = SUM_W'({r_gap, 2'b00});
    assign sum1 = {{3{r_sd[COST_W-1]}}, r_sd}
                + {{3{tab_rdata[COST_W-1]}}, tab_rdata}
                - {{3{r_ca[COST_W-1]}}, r_ca}
                - {{3{r_cb[COST_W-1]}}, r_cb};
    assign sum2 = {{3{r_sh[GAP_SPAN-1][COST_W-1]}}, r_sh[GAP_SPAN-1]}
                + signed'((r_i == r_la) ? '0 : span);
    assign sum3 = {{3{r_su[COST_W-1]}}, r_su}
                + signed'((r_j == r_lb) ? '0 : span);

    // An unreachable gap loses every compare.
    assign lt12    = !r_ok2 || (r_c1 < r_c2);
    assign lt13    = !r_ok3 || (r_c1 < r_c3);
    assign lt23    = r_ok2 && (!r_ok3 || (r_c2 < r_c3));
    assign mv_pick = lt12 ? (lt13 ? MV_DIAG : MV_UP) : (lt23 ? MV_LEFT : MV_UP);
    assign lt3m    = r_ok3 && (r_c3 < (lt12 ? r_c1 : r_c2));
    assign m_val   = lt3m ? r_c3 : (lt12 ? r_c1 : r_c2);

    // Traceback step from the move just read.
    always_comb begin
        tb_i     = r_i;
        tb_j     = r_j;
        tb_steps = 3'd1;
        if (r_i != '0 && r_j != '0) begin
            case (mv_rdata)
                MV_DIAG: begin
                    tb_i = r_i - 1'b1;
                    tb_j = r_j - 1'b1;
                end
                MV_UP: begin
                    tb_steps = (r_i >= LEN_W'(GAP_SPAN)) ? 3'(GAP_SPAN) : r_i[2:0];
                    tb_i     = r_i - LEN_W'(tb_steps);
                end
                default: begin
                    tb_steps = (r_j >= LEN_W'(GAP_SPAN)) ? 3'(GAP_SPAN) : r_j[2:0];
                    tb_j     = r_j - LEN_W'(tb_steps);
                end
            endcase
        end else if (r_i != '0) begin
            tb_i = r_i - 1'b1;
        end else begin
            tb_j = r_j - 1'b1;
        end
    end

    assign tb_f = (r_plen == '0) ? mv_rdata : r_first;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_la   <= la_sat;
            r_lb   <= lb_sat;
            r_i    <= '0;
            r_j    <= '0;
            r_slot <= '0;
            r_acc0 <= '0;
            r_accr <= '0;
            r_plen <= '0;
            r_lead <= '0;
            r_run  <= 1'b1;
        end
        if (i_cmd.row0) begin
            r_acc0 <= r_acc0 + ACC_W'(r_gap);
            if (r_j != r_lb) begin
                r_j <= j_nx;
            end
        end
        if (i_cmd.row_begin) begin
            r_i    <= r_i + 1'b1;
            r_j    <= '0;
            r_slot <= slot_m4;
            r_accr <= r_accr + ACC_W'(r_gap);
        end
        if (i_cmd.col0) begin
            r_bin_a <= seqa_rdata[SEQ_W-1:COST_W];
            r_ca    <= seqa_rdata[COST_W-1:0];
        end
        if (i_cmd.col0 || i_cmd.cell_wr) begin
            r_sh[0] <= sc_wdata;
            for (int k = 1; k < GAP_SPAN; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
        if (i_cmd.cell_rd) begin
            r_j <= j_nx;
        end
        if (i_cmd.cell_tab) begin
            r_sd <= sd_rdata;
            r_su <= su_rdata;
            r_cb <= seqb_rdata[COST_W-1:0];
        end
        if (i_cmd.cell_sum) begin
            r_c1  <= sat_sum(sum1);
            r_c2  <= sat_sum(sum2);
            r_c3  <= sat_sum(sum3);
            r_ok2 <= (r_j >= LEN_W'(GAP_SPAN));
            r_ok3 <= (r_i >= LEN_W'(GAP_SPAN));
        end
        if (i_cmd.fin_lat) begin
            r_dist <= sd_rdata;
        end
        if (i_cmd.tb_step) begin
            r_i     <= tb_i;
            r_j     <= tb_j;
            r_first <= tb_f;
            r_plen  <= r_plen + PLEN_W'(tb_steps);
            // extend the leading run while moves repeat a gap
            if (r_run && tb_f != MV_DIAG && mv_rdata == tb_f) begin
                r_lead <= r_lead + PLEN_W'(tb_steps);
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_status.j_last    = (r_j == r_lb);
    assign o_status.i_last    = (r_i == r_la);
    assign o_status.at_origin = (r_i == '0) && (r_j == '0);
    assign o_status.tb_last   = (tb_i == '0) && (tb_j == '0);

    assign o_distance        = r_dist;
    assign o_path_length     = r_plen;
    assign o_compared_length = r_plen - r_lead;
endmodule
`default_nettype wire

// ===== rtl/flowgram_gapped_alignment.sv =====
// Top level of the flowgram gapped aligner: controller plus datapath.
//
//  channel   handshake             payload
//  request   start / busy          i_mode, i_table_*, i_flow_*, i_len_a, i_len_b
//  result    o_valid (one cycle)   o_distance, o_path_length, o_compared_length
//  config    i_cfg_we              i_cfg_wdata (gap cost per flow, unsigned Q15.16)
//
// Load requests are accepted one per cycle, back to back, while busy is low.
// An align request fills the matrix row by row (row 0, then per row a row start,
// column 0 and each cell: sequence read, table read, sums, compare and write),
// then traces back one move at a time; the lengths are clamped to MAX_FLOWS.
// Synchronous active-low reset; the stores are undefined until loaded.
// busy is high from align accept through the result strobe; results cannot be stalled.
`default_nettype none
module flowgram_gapped_alignment import fga_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_mode,
    input  wire logic [BIN_W-1:0]         i_table_row,
    input  wire logic [BIN_W-1:0]         i_table_col,
    input  wire logic signed [COST_W-1:0] i_table_value,
    input  wire logic [FLOW_AW-1:0]       i_flow_index,
    input  wire logic [BIN_W-1:0]         i_flow_bin,
    input  wire logic signed [COST_W-1:0] i_flow_cost,
    input  wire logic [LEN_W-1:0]         i_len_a,
    input  wire logic [LEN_W-1:0]         i_len_b,
    input  wire logic                     i_cfg_we,
    input  wire logic [GAP_W-1:0]         i_cfg_wdata,
    output logic                          o_valid,
    output logic signed [COST_W-1:0]      o_distance,
    output logic [PLEN_W-1:0]             o_path_length,
    output logic [PLEN_W-1:0]             o_compared_length
);
    t_cmd    cmd;
    t_status status;

    fga_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    fga_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_mode            (i_mode),
        .i_table_row       (i_table_row),
        .i_table_col       (i_table_col),
        .i_table_value     (i_table_value),
        .i_flow_index      (i_flow_index),
        .i_flow_bin        (i_flow_bin),
        .i_flow_cost       (i_flow_cost),
        .i_len_a           (i_len_a),
        .i_len_b           (i_len_b),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_distance        (o_distance),
        .o_path_length     (o_path_length),
        .o_compared_length (o_compared_length)
    );
endmodule
`default_nettype wire
